[rtl/resp3_element_parser_top_assert.svh]
// ---------------------------------------------------------------------------
// RESP3 element parser assertion macros
// Shared concurrent assertion macros that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef RESP3_ELEMENT_PARSER_TOP_ASSERT_SVH
`define RESP3_ELEMENT_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RESP3_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("resp3 assertion failed");
`define RESP3_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("resp3 assertion failed");
`else
`define RESP3_ASSERT(lbl, clk, rst, prop)
`define RESP3_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/resp3p_pkg.sv]
// ---------------------------------------------------------------------------
// RESP3 parser package
// Shared codes, characters, limit defaults and the result and config records.
// ---------------------------------------------------------------------------
package resp3p_pkg;
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_DONE    = 2'd2;
   localparam logic [1:0] EV_ERROR   = 2'd3;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_INVALID     = 2'd1;
   localparam logic [1:0] ERR_OVERSIZE    = 2'd2;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

   localparam logic [3:0] T_STR      = 4'd0;
   localparam logic [3:0] T_ERR      = 4'd1;
   localparam logic [3:0] T_BLOB     = 4'd2;
   localparam logic [3:0] T_BLOB_ERR = 4'd3;
   localparam logic [3:0] T_VERBATIM = 4'd4;
   localparam logic [3:0] T_NUMBER   = 4'd5;
   localparam logic [3:0] T_NIL      = 4'd6;
   localparam logic [3:0] T_BOOL     = 4'd7;
   localparam logic [3:0] T_ARRAY    = 4'd8;
   localparam logic [3:0] T_MAP      = 4'd9;
   localparam logic [3:0] T_SET      = 4'd10;
   localparam logic [3:0] T_ATTR     = 4'd11;
   localparam logic [3:0] T_PUSH     = 4'd12;
   localparam logic [3:0] T_DOUBLE   = 4'd13;

   localparam logic [1:0] REG_MAX_SIMPLE = 2'd0;
   localparam logic [1:0] REG_MAX_BLOB   = 2'd1;
   localparam logic [1:0] REG_MAX_AGG    = 2'd2;

   localparam logic [15:0] MAX_SIMPLE_RESET = 16'd255;
   localparam logic [31:0] MAX_BLOB_RESET   = 32'd536870912;
   localparam logic [31:0] MAX_AGG_RESET    = 32'd67108864;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  payload_byte;
      logic [3:0]  element_type;
      logic [63:0] value;
      logic [1:0]  error_code;
      logic        last;
   } res_type;

   typedef struct packed {
      logic [15:0] max_simple_length;
      logic [31:0] max_blob_length;
      logic [31:0] max_aggregate_count;
   } cfg_type;
endpackage

[rtl/resp3p_core.sv]
// ---------------------------------------------------------------------------
// RESP3 parser core
// Parser state registers and the per-byte decode of up to two results.
// ---------------------------------------------------------------------------
module resp3p_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  resp3p_pkg::cfg_type cfg,
   output resp3p_pkg::res_type r0,
   output resp3p_pkg::res_type r1,
   output logic              two
);
   typedef enum logic [3:0] {
      PH_IDLE, PH_SIMPLE, PH_NUM_FIRST, PH_NUM, PH_LEN, PH_LEN_LF,
      PH_PAYLOAD, PH_END_CR, PH_BOOL, PH_END_LF
   } phase_type;

   phase_type   ph_ff, ph_in;
   logic [3:0]  type_ff, type_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        ds_ff, ds_in;
   logic [31:0] lc_ff, lc_in;
   logic        held_ff, held_in;
   logic        vm_ff, vm_in;

   logic        is_digit;
   logic [3:0]  d;
   logic [67:0] nv;
   logic [67:0] lim;
   logic [31:0] lc1, lc2;
   logic [63:0] gap;

   function automatic resp3p_pkg::res_type mk(logic [1:0] ev, logic [7:0] pay,
                                               logic [3:0] ty, logic [63:0] val,
                                               logic [1:0] err);
      resp3p_pkg::res_type r;
      r.event_res    = ev;
      r.payload_byte = pay;
      r.element_type = ty;
      r.value        = val;
      r.error_code   = err;
      r.last         = 1'b0;
      return r;
   endfunction

   assign is_digit = (in_byte >= resp3p_pkg::CH_ZERO) && (in_byte <= resp3p_pkg::CH_NINE);
   assign d   = is_digit ? 4'(in_byte - resp3p_pkg::CH_ZERO) : 4'd0;
   assign nv  = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {64'd0, d};
   assign lc1 = lc_ff + 32'd1;
   assign lc2 = lc_ff + 32'd2;
   assign gap = acc_ff - {32'd0, lc_ff};

   always_comb begin
      ph_in = ph_ff; type_in = type_ff; acc_in = acc_ff; neg_in = neg_ff;
      ds_in = ds_ff; lc_in = lc_ff; held_in = held_ff; vm_in = vm_ff;
      r0  = mk(resp3p_pkg::EV_NONE, 8'd0, 4'd0, 64'd0, resp3p_pkg::ERR_NONE);
      r1  = r0;
      two = 1'b0;
      lim = 68'd0;
      case (ph_ff)
         PH_SIMPLE: begin
            if (held_ff) begin
               held_in = 1'b0;
               if (in_byte == resp3p_pkg::CH_LF) begin
                  ph_in = PH_IDLE;
                  r0 = mk(resp3p_pkg::EV_DONE, 8'd0, type_ff, {32'd0, lc_ff},
                          resp3p_pkg::ERR_NONE);
               end else if (lc1 > {16'd0, cfg.max_simple_length}) begin
                  ph_in = PH_IDLE;
                  r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                          resp3p_pkg::ERR_OVERSIZE);
               end else begin
                  // The held CR was content; emit it, then handle this byte.
                  r0 = mk(resp3p_pkg::EV_PAYLOAD, resp3p_pkg::CH_CR, type_ff, 64'd0,
                          resp3p_pkg::ERR_NONE);
                  lc_in = lc1;
                  if (in_byte == resp3p_pkg::CH_CR) begin
                     held_in = 1'b1;
                  end else begin
                     two = 1'b1;
                     if (lc2 > {16'd0, cfg.max_simple_length}) begin
                        ph_in = PH_IDLE;
                        r1 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                                resp3p_pkg::ERR_OVERSIZE);
                     end else begin
                        lc_in = lc2;
                        r1 = mk(resp3p_pkg::EV_PAYLOAD, in_byte, type_ff, 64'd0,
                                resp3p_pkg::ERR_NONE);
                     end
                  end
               end
            end else if (in_byte == resp3p_pkg::CH_CR) begin
               held_in = 1'b1;
            end else if (lc1 > {16'd0, cfg.max_simple_length}) begin
               ph_in = PH_IDLE;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_OVERSIZE);
            end else begin
               lc_in = lc1;
               r0 = mk(resp3p_pkg::EV_PAYLOAD, in_byte, type_ff, 64'd0,
                       resp3p_pkg::ERR_NONE);
            end
         end
         PH_NUM_FIRST, PH_NUM: begin
            ph_in = PH_NUM;
            lim = neg_ff ? (68'd1 << 63) : ((68'd1 << 63) - 68'd1);
            if (ph_ff == PH_NUM_FIRST && in_byte == resp3p_pkg::CH_MINUS) begin
               neg_in = 1'b1;
            end else if (is_digit) begin
               if (nv > lim) begin
                  ph_in = PH_IDLE; held_in = 1'b0;
                  r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                          resp3p_pkg::ERR_OVERSIZE);
               end else begin
                  acc_in = nv[63:0];
                  ds_in  = 1'b1;
               end
            end else if (in_byte == resp3p_pkg::CH_CR && ds_ff) begin
               ph_in = PH_END_LF;
            end else begin
               ph_in = PH_IDLE; held_in = 1'b0;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_INVALID);
            end
         end
         PH_LEN: begin
            lim = (type_ff >= resp3p_pkg::T_ARRAY) ? {36'd0, cfg.max_aggregate_count}
                                                   : {36'd0, cfg.max_blob_length};
            if (is_digit) begin
               if (nv > lim) begin
                  ph_in = PH_IDLE; held_in = 1'b0;
                  r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                          resp3p_pkg::ERR_OVERSIZE);
               end else begin
                  acc_in = nv[63:0];
                  ds_in  = 1'b1;
               end
            end else if (in_byte == resp3p_pkg::CH_CR && ds_ff) begin
               ph_in = PH_LEN_LF;
            end else begin
               ph_in = PH_IDLE; held_in = 1'b0;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_INVALID);
            end
         end
         PH_LEN_LF: begin
            if (in_byte != resp3p_pkg::CH_LF) begin
               ph_in = PH_IDLE; held_in = 1'b0;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_INVALID);
            end else if (type_ff >= resp3p_pkg::T_ARRAY) begin
               ph_in = PH_IDLE;
               r0 = mk(resp3p_pkg::EV_DONE, 8'd0, type_ff,
                       (type_ff == resp3p_pkg::T_MAP) ? (acc_ff << 1) : acc_ff,
                       resp3p_pkg::ERR_NONE);
            end else begin
               lc_in = acc_ff[31:0];
               vm_in = 1'b0;
               ph_in = (acc_ff[31:0] == 32'd0) ? PH_END_CR : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (gap == 64'd3 && in_byte == resp3p_pkg::CH_COLON) vm_in = 1'b1;
            lc_in = lc_ff - 32'd1;
            if (lc_ff == 32'd1) ph_in = PH_END_CR;
            r0 = mk(resp3p_pkg::EV_PAYLOAD, in_byte, type_ff, 64'd0, resp3p_pkg::ERR_NONE);
         end
         PH_BOOL: begin
            if (in_byte == resp3p_pkg::CH_T || in_byte == resp3p_pkg::CH_F) begin
               acc_in = (in_byte == resp3p_pkg::CH_T) ? 64'd1 : 64'd0;
               ph_in  = PH_END_CR;
            end else begin
               ph_in = PH_IDLE; held_in = 1'b0;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_INVALID);
            end
         end
         PH_END_CR: begin
            if (in_byte == resp3p_pkg::CH_CR) begin
               ph_in = PH_END_LF;
            end else begin
               ph_in = PH_IDLE; held_in = 1'b0;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_INVALID);
            end
         end
         PH_END_LF: begin
            ph_in = PH_IDLE;
            if (in_byte != resp3p_pkg::CH_LF ||
                (type_ff == resp3p_pkg::T_VERBATIM && !(acc_ff > 64'd4 && vm_ff))) begin
               held_in = 1'b0;
               r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, type_ff, 64'd0,
                       resp3p_pkg::ERR_INVALID);
            end else begin
               r0 = mk(resp3p_pkg::EV_DONE, 8'd0, type_ff,
                       neg_ff ? (64'd0 - acc_ff) : acc_ff, resp3p_pkg::ERR_NONE);
            end
         end
         default: begin
            acc_in = 64'd0; neg_in = 1'b0; ds_in = 1'b0; lc_in = 32'd0;
            held_in = 1'b0; vm_in = 1'b0;
            case (in_byte)
               resp3p_pkg::CH_PLUS:   begin type_in = resp3p_pkg::T_STR;      ph_in = PH_SIMPLE; end
               resp3p_pkg::CH_MINUS:  begin type_in = resp3p_pkg::T_ERR;      ph_in = PH_SIMPLE; end
               resp3p_pkg::CH_DOLLAR: begin type_in = resp3p_pkg::T_BLOB;     ph_in = PH_LEN; end
               resp3p_pkg::CH_BANG:   begin type_in = resp3p_pkg::T_BLOB_ERR; ph_in = PH_LEN; end
               resp3p_pkg::CH_EQUAL:  begin type_in = resp3p_pkg::T_VERBATIM; ph_in = PH_LEN; end
               resp3p_pkg::CH_COLON:  begin type_in = resp3p_pkg::T_NUMBER;   ph_in = PH_NUM_FIRST; end
               resp3p_pkg::CH_UNDER:  begin type_in = resp3p_pkg::T_NIL;      ph_in = PH_END_CR; end
               resp3p_pkg::CH_HASH:   begin type_in = resp3p_pkg::T_BOOL;     ph_in = PH_BOOL; end
               resp3p_pkg::CH_STAR:   begin type_in = resp3p_pkg::T_ARRAY;    ph_in = PH_LEN; end
               resp3p_pkg::CH_PCT:    begin type_in = resp3p_pkg::T_MAP;      ph_in = PH_LEN; end
               resp3p_pkg::CH_TILDE:  begin type_in = resp3p_pkg::T_SET;      ph_in = PH_LEN; end
               resp3p_pkg::CH_PIPE:   begin type_in = resp3p_pkg::T_ATTR;     ph_in = PH_LEN; end
               resp3p_pkg::CH_GT:     begin type_in = resp3p_pkg::T_PUSH;     ph_in = PH_LEN; end
               resp3p_pkg::CH_COMMA, resp3p_pkg::CH_LPAREN: begin
                  type_in = resp3p_pkg::T_DOUBLE; ph_in = PH_IDLE;
                  r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, resp3p_pkg::T_DOUBLE, 64'd0,
                          resp3p_pkg::ERR_UNSUPPORTED);
               end
               default: begin
                  type_in = resp3p_pkg::T_STR; ph_in = PH_IDLE;
                  r0 = mk(resp3p_pkg::EV_ERROR, 8'd0, resp3p_pkg::T_STR, 64'd0,
                          resp3p_pkg::ERR_INVALID);
               end
            endcase
         end
      endcase
      r0.last = !two;
      r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; type_ff <= 4'd0; acc_ff <= 64'd0; neg_ff <= 1'b0;
         ds_ff <= 1'b0; lc_ff <= 32'd0; held_ff <= 1'b0; vm_ff <= 1'b0;
      end else if (accept) begin
         ph_ff <= ph_in; type_ff <= type_in; acc_ff <= acc_in; neg_ff <= neg_in;
         ds_ff <= ds_in; lc_ff <= lc_in; held_ff <= held_in; vm_ff <= vm_in;
      end
   end
endmodule

[rtl/resp3p_outq.sv]
// ---------------------------------------------------------------------------
// RESP3 parser result queue
// Result register plus one overflow slot for the second result of a byte.
// ---------------------------------------------------------------------------
`include "resp3_element_parser_top_assert.svh"
module resp3p_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_stall,
   input  resp3p_pkg::res_type r0,
   input  resp3p_pkg::res_type r1,
   input  logic              two,
   output logic              req_stall,
   output logic              accept,
   output logic              rsp_valid,
   output resp3p_pkg::res_type rsp
);
   logic                out_valid_ff, out_valid_in;
   logic                pend_valid_ff, pend_valid_in;
   resp3p_pkg::res_type out_ff, out_in;
   resp3p_pkg::res_type pend_ff, pend_in;
   logic                out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff; pend_valid_in = pend_valid_ff;
      out_in = out_ff; pend_in = pend_ff;
      if (accept) begin
         out_valid_in = 1'b1; out_in = r0;
         pend_valid_in = two; pend_in = r1;
      end else if (pend_valid_ff && out_free) begin
         out_valid_in = 1'b1; out_in = pend_ff;
         pend_valid_in = 1'b0;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0; pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in; pend_valid_ff <= pend_valid_in;
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   `RESP3_ASSERT(a_pend_has_out, clock, reset, pend_valid_ff |-> out_valid_ff)
   `RESP3_ASSERT(a_two_fills_pend, clock, reset, (accept && two) |=> pend_valid_ff)
   `RESP3_ASSERT(a_first_waits, clock, reset, (out_valid_ff && !out_ff.last) |-> pend_valid_ff)
   `RESP3_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !out_valid_ff && !pend_valid_ff)
endmodule

[rtl/resp3_element_parser_top.sv]
// ---------------------------------------------------------------------------
// RESP3 element parser top level
// Byte-serial RESP3 element and aggregate header parser with limit registers.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  req_     in         valid / stall        one stream byte per transaction
//  rsp_     out        valid / stall        one parse result per transaction
//  csr_     in         valid / ready        register index and write data
//
// Each byte is decoded in the cycle it is accepted and its first result is
// registered for the next cycle, so one byte is taken per clock while the
// output register is free and no second result waits. A byte yielding two
// results (a held carriage return turning out to be content) holds req_stall
// high until the second result enters the output register. Reset is
// synchronous and restores the parser to waiting for a type header and the
// limit registers to their defaults; a stalled result blocks new bytes.
module resp3_element_parser_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_res,
   output logic [7:0]         rsp_payload_byte,
   output logic [3:0]         rsp_element_type,
   output logic signed [63:0] rsp_value,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   resp3p_pkg::cfg_type cfg_ff;
   resp3p_pkg::res_type r0, r1, rsp;
   logic                two, accept;

   // The limit registers are always writable; writes to unused indexes drop.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_simple_length   <= resp3p_pkg::MAX_SIMPLE_RESET;
         cfg_ff.max_blob_length     <= resp3p_pkg::MAX_BLOB_RESET;
         cfg_ff.max_aggregate_count <= resp3p_pkg::MAX_AGG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            resp3p_pkg::REG_MAX_SIMPLE: cfg_ff.max_simple_length   <= csr_data[15:0];
            resp3p_pkg::REG_MAX_BLOB:   cfg_ff.max_blob_length     <= csr_data;
            resp3p_pkg::REG_MAX_AGG:    cfg_ff.max_aggregate_count <= csr_data;
            default: ;
         endcase
      end
   end

   // The core holds the parser state and decodes the accepted byte.
   resp3p_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .cfg     (cfg_ff),
      .r0      (r0),
      .r1      (r1),
      .two     (two)
   );

   // The queue registers results and decides when a new byte may enter.
   resp3p_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .r0        (r0),
      .r1        (r1),
      .two       (two),
      .req_stall (req_stall),
      .accept    (accept),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_event_res    = rsp.event_res;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_element_type = rsp.element_type;
   assign rsp_value        = rsp.value;
   assign rsp_error_code   = rsp.error_code;
   assign rsp_last         = rsp.last;
endmodule
